// ----- src/mm4_pkg.sv -----
// shared types and constants for the 4x4 fixed-point matrix multiply unit
// used by the controller, the datapath and the top level; no dependencies
package mm4_pkg;

  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int RC_W  = $clog2(DIM);
  localparam int IDX_W = 2 * RC_W;
  localparam int VAL_W = 32;
  // full-width sum of DIM products of two VAL_W operands
  localparam int ACC_W = 2 * VAL_W + RC_W;

  typedef struct packed {
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic [IDX_W-1:0]        element_index;
    logic                    start_compute;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [RC_W-1:0]         out_row;
    logic [RC_W-1:0]         out_col;
    logic                    last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic             rd_first;
    logic             rd_last;
    logic [IDX_W-1:0] rd_left_addr;
    logic [IDX_W-1:0] rd_right_addr;
    logic             load_out;
    logic [RC_W-1:0]  out_row;
    logic [RC_W-1:0]  out_col;
    logic             out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/matrix4_multiply_unit.sv -----
// 4x4 signed Q16.16 matrix multiply unit, top level
// joins mm4_ctrl and mm4_datapath; uses mm4_pkg
//
// input channel (in_valid/in_ready/in_data): each beat stores a_value into A
// and b_value into B at element_index (row*4+col). a beat with start_compute
// set is stored first and then starts the product C = A x B.
// output channel (out_valid/out_ready/out_data): sixteen beats in row-major
// order, each with its row and column; last_of_run marks the final one.
// each element is the exact sum of four products, shifted right by FRAC_BITS
// (floor) and saturated to 32 bits.
// load beats are accepted back to back while idle. after the starting beat
// the unit computes one element at a time (four store reads, the multiplier
// stage and the accumulate) and starts the next only once the previous one is
// loaded into the output register, as the unit has a single shared
// multiplier and one read port per store.
// in_ready is low for the whole run and high again once the last element
// sits in the output register. a stalled receiver holds that register and
// the sequence waits for it. reset returns the unit to idle with no output
// pending; the stores keep no defined contents until written.
module matrix4_multiply_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mm4_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mm4_pkg::out_beat_t out_data
);

  mm4_pkg::ctrl_cmd_t cmd;
  mm4_pkg::dp_sts_t   sts;

  mm4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  mm4_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_start_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.start_compute |=> !in_ready)
    else $error("input still taken after a starting beat");

  a_load_needs_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.acc_done && sts.out_free)
    else $error("result loaded without a finished sum or a free output slot");

  a_no_read_while_loading: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !cmd.wr_en)
    else $error("store read during a load beat");

  a_last_is_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_of_run ==
                   (out_data.out_row == mm4_pkg::RC_W'(mm4_pkg::DIM - 1) &&
                    out_data.out_col == mm4_pkg::RC_W'(mm4_pkg::DIM - 1))))
    else $error("last_of_run not on the final element");

endmodule

// ----- src/mm4_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/mm4_ctrl.sv -----
// sequencer for the matrix multiply: load phase, then per result cell
// four read steps and a wait for the sum and a free output slot; uses mm4_pkg
module mm4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mm4_pkg::in_beat_t in_data,
  input  mm4_pkg::dp_sts_t  sts,
  output mm4_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [mm4_pkg::IDX_W-1:0]   elem;
  logic [mm4_pkg::IDX_W-1:0]   elem_next;
  logic [mm4_pkg::RC_W-1:0]    k;
  logic [mm4_pkg::RC_W-1:0]    k_next;
  logic [mm4_pkg::RC_W-1:0]    row;
  logic [mm4_pkg::RC_W-1:0]    col;
  logic                        accept;
  logic                        last_k;
  logic                        last_cell;

  assign row       = elem[mm4_pkg::IDX_W-1:mm4_pkg::RC_W];
  assign col       = elem[mm4_pkg::RC_W-1:0];
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_k    = (k == mm4_pkg::RC_W'(mm4_pkg::DIM - 1));
  assign last_cell = (elem == mm4_pkg::IDX_W'(mm4_pkg::CELLS - 1));

  always_comb begin
    cmd               = '0;
    cmd.wr_en         = accept &&
                        ({1'b0, in_data.element_index} <
                         (mm4_pkg::IDX_W + 1)'(mm4_pkg::CELLS));
    cmd.rd_en         = (state == ST_RUN);
    cmd.rd_first      = (k == '0);
    cmd.rd_last       = last_k;
    cmd.rd_left_addr  = {row, k};
    cmd.rd_right_addr = {k, col};
    cmd.load_out      = (state == ST_WAIT) && sts.acc_done && sts.out_free;
    cmd.out_row       = row;
    cmd.out_col       = col;
    cmd.out_last      = last_cell;
  end

  always_comb begin
    state_next = state;
    elem_next  = elem;
    k_next     = k;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.start_compute) begin
          state_next = ST_RUN;
          elem_next  = '0;
          k_next     = '0;
        end
      end
      ST_RUN: begin
        k_next = k + 1'b1;
        if (last_k) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (cmd.load_out) begin
          if (last_cell) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RUN;
            elem_next  = elem + 1'b1;
            k_next     = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      elem  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      elem  <= elem_next;
      k     <= k_next;
    end
  end

endmodule

// ----- src/mm4_datapath.sv -----
// operand stores, multiplier, accumulator, shift/saturate and output register
// uses mm4_pkg and mm4_ram
module mm4_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mm4_pkg::in_beat_t  in_data,
  input  mm4_pkg::ctrl_cmd_t cmd,
  output mm4_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output mm4_pkg::out_beat_t out_data
);

  logic [mm4_pkg::VAL_W-1:0]          left_rd;
  logic [mm4_pkg::VAL_W-1:0]          right_rd;
  logic                               s1_valid;
  logic                               s1_first;
  logic                               s1_last;
  logic                               s2_valid;
  logic                               s2_first;
  logic                               s2_last;
  logic signed [2*mm4_pkg::VAL_W-1:0] prod;
  logic signed [mm4_pkg::ACC_W-1:0]   prod_ext;
  logic signed [mm4_pkg::ACC_W-1:0]   acc;
  logic signed [mm4_pkg::ACC_W-1:0]   shifted;
  logic [mm4_pkg::ACC_W-mm4_pkg::VAL_W:0] upper;
  logic signed [mm4_pkg::VAL_W-1:0]   sat_value;
  logic                               acc_done;

  mm4_ram #(.WIDTH(mm4_pkg::VAL_W), .DEPTH(mm4_pkg::CELLS)) u_left_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (in_data.element_index),
    .wdata (in_data.a_value),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_left_addr),
    .rdata (left_rd)
  );

  mm4_ram #(.WIDTH(mm4_pkg::VAL_W), .DEPTH(mm4_pkg::CELLS)) u_right_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (in_data.element_index),
    .wdata (in_data.b_value),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_right_addr),
    .rdata (right_rd)
  );

  // stage 2: one signed 32x32 product per step, then the accumulate and the output load
  always_ff @(posedge clk) begin
    prod     <= $signed(left_rd) * $signed(right_rd);
    s1_first <= cmd.rd_first;
    s1_last  <= cmd.rd_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    if (s2_valid) begin
      acc <= s2_first ? prod_ext : acc + prod_ext;
    end
    if (cmd.load_out) begin
      out_data.product_value <= sat_value;
      out_data.out_row       <= cmd.out_row;
      out_data.out_col       <= cmd.out_col;
      out_data.last_of_run   <= cmd.out_last;
    end
  end

  assign prod_ext = mm4_pkg::ACC_W'(prod);

  // floor shift of the exact sum, then clamp to 32 bits
  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[mm4_pkg::ACC_W-1:mm4_pkg::VAL_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_value = shifted[mm4_pkg::VAL_W-1:0];
    end else if (upper[mm4_pkg::ACC_W-mm4_pkg::VAL_W]) begin
      sat_value = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      if (s2_valid && s2_last) begin
        acc_done <= 1'b1;
      end else if (cmd.load_out) begin
        acc_done <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.acc_done = acc_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// regression bench for the 4x4 Q16.16 matrix multiply unit
// uses mm4_pkg and matrix4_multiply_unit; predicts every product element in the bench
module tb;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [mm4_pkg::VAL_W-1:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic [mm4_pkg::VAL_W-1:0] MIN_Q = 32'h8000_0000;
  localparam logic signed [mm4_pkg::ACC_W-1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [mm4_pkg::ACC_W-1:0] SAT_LO = -66'sd2147483648;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  mm4_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  mm4_pkg::out_beat_t out_data;

  // bench copy of the operand stores
  logic signed [mm4_pkg::VAL_W-1:0] a_store[mm4_pkg::CELLS];
  logic signed [mm4_pkg::VAL_W-1:0] b_store[mm4_pkg::CELLS];
  mm4_pkg::out_beat_t pending_products[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int mismatches;
  int unsigned cycles;
  mm4_pkg::out_beat_t want;

  matrix4_multiply_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // exact sum of products, floor shift, then clamp to 32 bits
  function automatic logic signed [mm4_pkg::VAL_W-1:0] product_cell(int row, int col);
    logic signed [mm4_pkg::ACC_W-1:0] acc;
    logic signed [mm4_pkg::ACC_W-1:0] lhs;
    logic signed [mm4_pkg::ACC_W-1:0] rhs;
    int k;
    acc = '0;
    for (k = 0; k < mm4_pkg::DIM; k++) begin
      lhs = a_store[row * mm4_pkg::DIM + k];
      rhs = b_store[k * mm4_pkg::DIM + col];
      acc = acc + lhs * rhs;
    end
    acc = acc >>> FRAC;
    if (acc > SAT_HI) return MAX_Q;
    if (acc < SAT_LO) return MIN_Q;
    return acc[mm4_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [mm4_pkg::VAL_W-1:0] rand_q16();
    case ($urandom_range(9))
      0: return MAX_Q;
      1: return MIN_Q;
      2, 3: return $urandom();
      // mostly within +-4.0 so sums stay clear of saturation
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic send_item(input mm4_pkg::in_beat_t beat);
    int r;
    int c;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    a_store[beat.element_index] = beat.a_value;
    b_store[beat.element_index] = beat.b_value;
    if (beat.start_compute) begin
      for (r = 0; r < mm4_pkg::DIM; r++) begin
        for (c = 0; c < mm4_pkg::DIM; c++) begin
          pending_products.push_back('{product_cell(r, c), mm4_pkg::RC_W'(r),
                                       mm4_pkg::RC_W'(c),
                                       (r == mm4_pkg::DIM - 1) &&
                                       (c == mm4_pkg::DIM - 1)});
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // cover_all walks a shuffled full set of indexes; flagged ends with a start beat
  task automatic send_run(int n, bit cover_all, bit flagged);
    int order[mm4_pkg::CELLS];
    int i;
    int j;
    int t;
    mm4_pkg::in_beat_t beat;
    for (i = 0; i < mm4_pkg::CELLS; i++) order[i] = i;
    for (i = mm4_pkg::CELLS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < n; i++) begin
      beat.a_value       = rand_q16();
      beat.b_value       = rand_q16();
      beat.element_index = cover_all ? mm4_pkg::IDX_W'(order[i]) :
                           mm4_pkg::IDX_W'($urandom_range(mm4_pkg::CELLS - 1));
      beat.start_compute = flagged && (i == n - 1);
      send_item(beat);
    end
  endtask

  // rows 0..2 of A at max, row 3 at min; B columns alternate max and min
  task automatic test_saturation();
    int i;
    for (i = 0; i < mm4_pkg::CELLS; i++) begin
      send_item('{(i / mm4_pkg::DIM == mm4_pkg::DIM - 1) ? MIN_Q : MAX_Q,
                  (i % 2 == 0) ? MAX_Q : MIN_Q,
                  mm4_pkg::IDX_W'(i), i == mm4_pkg::CELLS - 1});
    end
  endtask

  // partial rewrite, start on a middle index, then a lone start beat
  task automatic test_partial_update();
    send_item('{32'h0001_0000, 32'hFFFF_0000, mm4_pkg::IDX_W'(0), 1'b0});
    send_item('{32'h0000_0000, 32'h0000_0000, mm4_pkg::IDX_W'(10), 1'b0});
    send_item('{MIN_Q, 32'h0000_0001, mm4_pkg::IDX_W'(5), 1'b1});
    send_item('{32'h0000_0001, 32'hFFFF_FFFF, mm4_pkg::IDX_W'(15), 1'b1});
  endtask

  task automatic test_random_phase(int tx_pct, int rx_pct, int budget);
    int sent;
    int kind;
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(9);
      if (kind < 2) n = mm4_pkg::CELLS;
      else if (kind < 9) n = $urandom_range(6, 1);
      else n = $urandom_range(3, 1);
      // kind 9 is loose beats with no start
      send_run(n, kind < 2, kind != 9);
      sent += n;
    end
  endtask

  // receiver stalls long while runs keep coming, so in_ready stays low
  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = 400;
    send_run(3, 1'b0, 1'b1);
    send_run(3, 1'b0, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_run(5, 1'b0, 1'b1);
    wait_drained();
    send_run(4, 1'b0, 1'b1);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %h row %0d col %0d last %0b",
                   out_data.product_value, out_data.out_row, out_data.out_col,
                   out_data.last_of_run);
      end else begin
        want = pending_products.pop_front();
        if (out_data.product_value !== want.product_value ||
            out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h r%0d c%0d l%0b, got %h r%0d c%0d l%0b",
                     want.product_value, want.out_row, want.out_col, want.last_of_run,
                     out_data.product_value, out_data.out_row, out_data.out_col,
                     out_data.last_of_run);
        end
      end
    end
  end

  initial begin
    mismatches  = 0;
    hold_left   = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 59;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturation();
    test_partial_update();
    test_random_phase(25, 59, 20);
    test_random_phase(59, 25, 20);
    test_output_hold();
    test_drain_pause();
    test_random_phase(0, 0, 20);

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_products.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
